>>> sv/sdas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdas_pkg
// Constants shared by the STORE DATA APDU segmenter.
// ----------------------------------------------------------------------------
package sdas_pkg;

  // Maximum data bytes per command APDU
  localparam logic [7:0] CHUNK = 8'd240;

  localparam logic [7:0] CLA_BASE      = 8'h80;
  localparam logic [7:0] CLA_EXT_CHAN  = 8'h40;
  localparam logic [7:0] INS_STORE     = 8'hE2;
  localparam logic [7:0] P1_MORE       = 8'h10;
  localparam logic [7:0] P1_LAST       = 8'h90;
  localparam logic [7:0] P1_RESP       = 8'h01;
  localparam logic [7:0] LE_BYTE       = 8'h00;
  localparam logic [4:0] CHAN_BASIC_MAX = 5'd3;
  localparam logic [4:0] CHAN_EXT_OFS   = 5'd4;

  // Byte slots of one command APDU fragment
  typedef enum logic [2:0] {
    SLOT_CLA  = 3'd0,
    SLOT_INS  = 3'd1,
    SLOT_P1   = 3'd2,
    SLOT_P2   = 3'd3,
    SLOT_LC   = 3'd4,
    SLOT_DATA = 3'd5,
    SLOT_LE   = 3'd6
  } slot_t;

  // Bytes produced by one accepted message byte
  typedef struct packed {
    logic [7:0] cla;
    logic [7:0] p1;
    logic [7:0] p2;
    logic [7:0] lc;
    logic [7:0] data;
    logic       has_le;
    logic       msg_end;
  } frag_t;

endpackage

>>> sv/store_data_apdu_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// store_data_apdu_segmenter
// Cuts a TLV byte stream into chained STORE DATA command APDUs.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one message byte per transaction; tdata carries the byte and the
//           total message length, tuser the response-expected flag.
//   out_* : the APDU byte stream, one byte per transaction; tlast marks the
//           Le byte closing each APDU, tuser marks the Le of the final APDU.
//   cfg_* : writes the logical channel number; always ready, write only
//           while the block is idle.
// Throughput: the output register moves one byte per cycle unless out_tready
//   stalls it; a message byte yields one APDU byte, two if it closes a chunk,
//   six if it opens one and seven if it does both. The next message byte is
//   taken in the cycle the previous one's last APDU byte moves to the output register.
// Path: an accepted transaction is held in the fragment register and its APDU
//   bytes pass through the output register before they are valid on the output.
// Reset: counters, channel and both valid flags clear; holding data is not reset.
// Stall: with out_tready low the output byte holds, the pending fragment
//   holds and in_tready drops until the fragment drains.
// ----------------------------------------------------------------------------
module store_data_apdu_segmenter
  import sdas_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] data_byte, [23:8] message_length
  input  logic [0:0]  in_tuser,   // [0] response_expected
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] apdu_byte
  output logic        out_tlast,
  output logic [0:0]  out_tuser,  // [0] message_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  logic [4:0]  channel_r, channel_nxt;
  logic [15:0] bytes_done_r, bytes_done_nxt;
  logic [7:0]  chunk_pos_r, chunk_pos_nxt;
  logic [7:0]  block_num_r, block_num_nxt;

  frag_t       frag_r, frag_nxt;
  logic        frag_valid_r, frag_valid_nxt;
  slot_t       slot_r, slot_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_mend_r, out_mend_nxt;

  logic [7:0]  data_in;
  logic [15:0] len_in;
  logic        resp_in;
  logic [15:0] pending;
  logic        msg_last, chunk_last, last_block, accept;
  logic [4:0]  ext_chan;
  logic        out_free, emit, frag_done;
  slot_t       last_slot;
  logic [7:0]  cur_byte;

  assign data_in = in_tdata[7:0];
  assign len_in  = in_tdata[23:8];
  assign resp_in = in_tuser[0];
  assign cfg_ready = 1'b1;

  assign out_free  = !out_valid_r || out_tready;
  assign emit      = frag_valid_r && out_free;
  assign last_slot = frag_r.has_le ? SLOT_LE : SLOT_DATA;
  assign frag_done = emit && (slot_r == last_slot);
  assign in_tready = !frag_valid_r || frag_done;
  assign accept    = in_tvalid && in_tready;

  // Remaining count is taken as one when the length is already reached
  assign pending    = (len_in > bytes_done_r) ? (len_in - bytes_done_r) : 16'd1;
  assign msg_last   = (pending == 16'd1);
  assign chunk_last = msg_last || ({1'b0, chunk_pos_r} + 9'd1 >= {1'b0, CHUNK});
  assign last_block = (pending <= {8'd0, CHUNK});
  assign ext_chan   = channel_r - CHAN_EXT_OFS;

  always_comb begin
    frag_nxt.cla     = (channel_r <= CHAN_BASIC_MAX) ? (CLA_BASE | {6'd0, channel_r[1:0]})
                                                     : (CLA_BASE | CLA_EXT_CHAN |
                                                        {4'd0, ext_chan[3:0]});
    frag_nxt.p1      = (last_block ? P1_LAST : P1_MORE) | (resp_in ? P1_RESP : 8'h00);
    frag_nxt.p2      = block_num_r;
    frag_nxt.lc      = last_block ? pending[7:0] : CHUNK;
    frag_nxt.data    = data_in;
    frag_nxt.has_le  = chunk_last;
    frag_nxt.msg_end = msg_last;
  end

  always_comb begin
    unique case (slot_r)
      SLOT_CLA:  cur_byte = frag_r.cla;
      SLOT_INS:  cur_byte = INS_STORE;
      SLOT_P1:   cur_byte = frag_r.p1;
      SLOT_P2:   cur_byte = frag_r.p2;
      SLOT_LC:   cur_byte = frag_r.lc;
      SLOT_DATA: cur_byte = frag_r.data;
      SLOT_LE:   cur_byte = LE_BYTE;
      default:   cur_byte = LE_BYTE;
    endcase
  end

  always_comb begin
    channel_nxt    = cfg_valid ? cfg_data : channel_r;
    bytes_done_nxt = bytes_done_r;
    chunk_pos_nxt  = chunk_pos_r;
    block_num_nxt  = block_num_r;
    frag_valid_nxt = frag_valid_r;
    slot_nxt       = slot_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_mend_nxt   = out_mend_r;

    if (accept) begin
      frag_valid_nxt = 1'b1;
      slot_nxt       = (chunk_pos_r == 8'd0) ? SLOT_CLA : SLOT_DATA;
      if (chunk_last && msg_last) begin
        bytes_done_nxt = 16'd0;
        chunk_pos_nxt  = 8'd0;
        block_num_nxt  = 8'd0;
      end else if (chunk_last) begin
        bytes_done_nxt = bytes_done_r + 16'd1;
        chunk_pos_nxt  = 8'd0;
        block_num_nxt  = block_num_r + 8'd1;
      end else begin
        bytes_done_nxt = bytes_done_r + 16'd1;
        chunk_pos_nxt  = chunk_pos_r + 8'd1;
      end
    end else if (frag_done) begin
      frag_valid_nxt = 1'b0;
    end else if (emit) begin
      slot_nxt = slot_t'(slot_r + 3'd1);
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = (slot_r == SLOT_LE);
      out_mend_nxt  = (slot_r == SLOT_LE) && frag_r.msg_end;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_r    <= 5'd0;
      bytes_done_r <= 16'd0;
      chunk_pos_r  <= 8'd0;
      block_num_r  <= 8'd0;
      frag_valid_r <= 1'b0;
      slot_r       <= SLOT_CLA;
      out_valid_r  <= 1'b0;
    end else begin
      channel_r    <= channel_nxt;
      bytes_done_r <= bytes_done_nxt;
      chunk_pos_r  <= chunk_pos_nxt;
      block_num_r  <= block_num_nxt;
      frag_valid_r <= frag_valid_nxt;
      slot_r       <= slot_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frag_r <= frag_nxt;
    end
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_mend_r <= out_mend_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_byte_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_mend_r;

`ifndef NO_ASSERTIONS
  a_mend_on_apdu_end : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("message end flagged on a byte that does not close an APDU");

  a_no_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    frag_valid_r && !out_free |-> !in_tready)
    else $error("input accepted while fragment is blocked");

  a_slot_range : assert property (@(posedge clk) disable iff (!rst_n)
    frag_valid_r |-> (slot_r <= last_slot))
    else $error("fragment slot ran past its last byte");

  a_reset_state : assert property (@(posedge clk)
    !rst_n |=> (bytes_done_r == 16'd0 && chunk_pos_r == 8'd0 && !out_valid_r))
    else $error("state not cleared by reset");
`endif

endmodule

>>> sim/tb_store_data_apdu_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_store_data_apdu_segmenter
// Drives message bytes into the STORE DATA segmenter, predicts the command
// APDU byte stream and checks every output transaction against it.
// Covers single-byte messages, a message that fills one chunk and spills one
// byte into a second block, length zero and length changed mid-message,
// and channels at both ends of the class byte coding. Both sides idle at
// random, and the receiver holds off once long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_store_data_apdu_segmenter;
  import sdas_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [7:0] apdu_byte;
    logic       apdu_end;
    logic       message_end;
  } apdu_beat_t;

  // Segmenter predictor plus the queue of APDU bytes still to arrive
  class apdu_scoreboard;
    logic [4:0]  channel;
    logic [15:0] bytes_done;
    logic [7:0]  chunk_pos;
    logic [7:0]  block_number;
    apdu_beat_t  beats_q[$];
    int          errors;

    function void reset_state();
      channel = '0;
      bytes_done = '0;
      chunk_pos = '0;
      block_number = '0;
      beats_q.delete();
      errors = 0;
    endfunction

    function void set_channel(logic [4:0] ch);
      channel = ch;
    endfunction

    function void push_beat(logic [7:0] b, logic aend, logic mend);
      apdu_beat_t beat;
      beat.apdu_byte = b;
      beat.apdu_end = aend;
      beat.message_end = mend;
      beats_q.push_back(beat);
    endfunction

    function void note_byte(logic [7:0] data, logic [15:0] len, logic resp);
      logic [15:0] pending;
      logic        msg_last;
      logic        chunk_last;
      logic        last_block;
      logic [7:0]  p1;
      logic [7:0]  lc;
      logic [7:0]  cla;
      logic [4:0]  ext;
      pending = (len > bytes_done) ? len - bytes_done : 16'd1;
      msg_last = (pending == 16'd1);
      chunk_last = msg_last || ({1'b0, chunk_pos} + 9'd1 >= {1'b0, CHUNK});
      if (chunk_pos == 8'd0) begin
        last_block = (pending <= {8'd0, CHUNK});
        p1 = last_block ? P1_LAST : P1_MORE;
        lc = last_block ? pending[7:0] : CHUNK;
        if (resp) p1 = p1 | P1_RESP;
        if (channel <= CHAN_BASIC_MAX) begin
          cla = CLA_BASE | {6'd0, channel[1:0]};
        end else begin
          ext = channel - CHAN_EXT_OFS;
          cla = CLA_BASE | CLA_EXT_CHAN | {4'd0, ext[3:0]};
        end
        push_beat(cla, 1'b0, 1'b0);
        push_beat(INS_STORE, 1'b0, 1'b0);
        push_beat(p1, 1'b0, 1'b0);
        push_beat(block_number, 1'b0, 1'b0);
        push_beat(lc, 1'b0, 1'b0);
      end
      push_beat(data, 1'b0, 1'b0);
      if (chunk_last) begin
        push_beat(LE_BYTE, 1'b1, msg_last);
        if (msg_last) begin
          bytes_done = '0;
          chunk_pos = '0;
          block_number = '0;
        end else begin
          bytes_done = bytes_done + 16'd1;
          chunk_pos = '0;
          block_number = block_number + 8'd1;
        end
      end else begin
        bytes_done = bytes_done + 16'd1;
        chunk_pos = chunk_pos + 8'd1;
      end
    endfunction

    function void check_beat(logic [7:0] b, logic aend, logic mend);
      apdu_beat_t exp_beat;
      if (beats_q.size() == 0) begin
        $display("%0t: unexpected APDU byte %02h tlast=%0b tuser=%0b",
                 $time, b, aend, mend);
        errors++;
        return;
      end
      exp_beat = beats_q.pop_front();
      if (b !== exp_beat.apdu_byte) begin
        $display("%0t: apdu_byte expected %02h actual %02h",
                 $time, exp_beat.apdu_byte, b);
        errors++;
      end
      if (aend !== exp_beat.apdu_end) begin
        $display("%0t: apdu_end expected %0b actual %0b",
                 $time, exp_beat.apdu_end, aend);
        errors++;
      end
      if (mend !== exp_beat.message_end) begin
        $display("%0t: message_end expected %0b actual %0b",
                 $time, exp_beat.message_end, mend);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [7:0] data_byte, [23:8] message_length
  logic [0:0]  in_tuser;   // [0] response_expected
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] apdu_byte
  logic        out_tlast;
  logic [0:0]  out_tuser;  // [0] message_end
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;

  apdu_scoreboard sb;
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;
  bit rx_started;
  int cycles;

  store_data_apdu_segmenter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
    $display("store_data_apdu_segmenter regression: fail");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] data, input logic [15:0] len,
                           input logic resp);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {len, data};
    in_tuser <= resp;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(data, len, resp);
    @(negedge clk);
  endtask

  task automatic send_message(input logic [15:0] len, input logic resp);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), len, resp);
  endtask

  // Drain every expected byte, let the block settle, then set the channel
  task automatic set_channel_idle(input logic [4:0] ch);
    in_tvalid <= 1'b0;
    while (sb.beats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= ch;
    do @(posedge clk); while (!cfg_ready);
    sb.set_channel(ch);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls per transaction, one long hold-off on request
  initial begin
    int gap;
    bit held;
    held = 0;
    wait (rx_started);
    @(negedge clk);
    forever begin
      if (hold_req && !held) begin
        gap = HOLD_CYCLES;
        held = 1;
      end else begin
        gap = rx_idle_on ? $urandom_range(0, 14) : 0;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_beat(out_tdata, out_tlast, out_tuser[0]);
      @(negedge clk);
    end
  end

  initial begin
    logic resp;
    sb = new();
    sb.reset_state();
    cycles = 0;
    tx_idle_on = 1;
    rx_idle_on = 1;
    hold_req = 0;
    rx_started = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    rx_started = 1;
    @(negedge clk);

    // Directed: single bytes, length zero, field extremes, channel coding
    set_channel_idle(5'd0);
    send_byte(8'h00, 16'd1, 1'b0);
    send_byte(8'hFF, 16'd1, 1'b1);
    send_byte(8'hA5, 16'd0, 1'b0);
    set_channel_idle(5'd3);
    send_byte(8'h00, 16'd3, 1'b1);
    send_byte(8'h7F, 16'd3, 1'b1);
    send_byte(8'h80, 16'd3, 1'b1);
    set_channel_idle(5'd4);
    // length shrinks mid-message: Lc already sent disagrees
    send_byte(8'h11, 16'd10, 1'b0);
    send_byte(8'h22, 16'd10, 1'b0);
    send_byte(8'h33, 16'd3, 1'b0);
    // header with the widest length, then closed by length zero
    send_byte(8'h44, 16'hFFFF, 1'b1);
    send_byte(8'h55, 16'd0, 1'b1);
    set_channel_idle(5'd19);
    send_message(16'd2, 1'b0);
    set_channel_idle(5'd31);
    send_message(16'd1, 1'b1);
    set_channel_idle(5'd20);
    send_message(16'd2, 1'b1);

    // One full chunk plus a one-byte last block; the receiver holds off
    // early while the sender keeps offering bytes
    set_channel_idle(5'($urandom_range(0, 19)));
    tx_idle_on = 0;
    rx_idle_on = 1;
    hold_req = 1;
    resp = 1'($urandom_range(0, 1));
    for (int i = 0; i < 241; i++) begin
      send_byte(8'($urandom_range(0, 255)), 16'd241, resp);
      if ($urandom_range(0, 31) == 0) tx_idle_on = ~tx_idle_on;
      if ($urandom_range(0, 31) == 0) rx_idle_on = ~rx_idle_on;
    end

    in_tvalid <= 1'b0;
    while (sb.beats_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.beats_q.size() != 0) begin
      $display("%0t: %0d APDU bytes expected, 0 arrived", $time, sb.beats_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("store_data_apdu_segmenter regression: pass");
    end else begin
      $display("store_data_apdu_segmenter regression: fail");
    end
    $finish;
  end

endmodule
